>>> rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the coalesced hash multiset.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int DEF_TABLE_SLOTS = 16;
   localparam int KEY_W           = 32;
   localparam int OCC_W           = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_COUNT  = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_ADD_HOME,
      ST_ADD_WALK,
      ST_ADD_NEW,
      ST_FREE,
      ST_SEARCH,
      ST_COUNT,
      ST_RM_FIND,
      ST_RM_SCAN,
      ST_RM_PSCAN,
      ST_RM_PREV,
      ST_RM_CLR,
      ST_DONE
   } state_type;

endpackage

>>> rtl/coalesced_hash_multiset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalesced_hash_multiset
// Multiset of signed keys in a fixed slot table with coalesced chaining.
// ----------------------------------------------------------------------------
// Raise start with req_operation and req_key while busy is low; that edge is
// the transfer. busy stays high until the result shows on the rsp_ ports,
// with rsp_valid high for that one cycle; the receiver cannot hold it off.
// Every item first passes through the home slot unit, one key byte at a
// time, then walks the slot table through the single read port, one slot a
// cycle, and ends in the done state, which registers the response. Search
// takes up to TABLE_SLOTS+1 slot reads, count exactly TABLE_SLOTS, add a
// chain walk plus a free slot scan (up to about 2*TABLE_SLOTS), remove a
// chain walk, up to TABLE_SLOTS relocation walks and at worst a predecessor
// scan.
// After reset a clearing pass writes every slot empty with busy high; no
// transfer is taken until it ends.
// ----------------------------------------------------------------------------
module coalesced_hash_multiset
   import chm_pkg::*;
#(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   output logic                    rsp_success,
   output logic [OCC_W-1:0]        rsp_occurrences,
   output logic [OCC_W-1:0]        rsp_element_total,
   output logic                    rsp_table_full
);

   localparam int            AW   = $clog2(TABLE_SLOTS);
   localparam int            IW   = $clog2(TABLE_SLOTS + 1);
   localparam int            EW   = 1 + IW + AW + KEY_W;
   localparam logic [IW-1:0] NONE = IW'(TABLE_SLOTS);
   localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [IW-1:0]    ptr_ff, ptr_in;       // slot whose entry is on rd_data
   logic [IW-1:0]    home_ff, home_in;
   logic [IW-1:0]    free_ff, free_in;
   logic [IW-1:0]    count_ff, count_in;
   logic [IW-1:0]    steps_ff, steps_in;
   logic [IW-1:0]    outer_ff, outer_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic [IW-1:0]    prev_ff, prev_in;
   logic [IW-1:0]    pprev_ff, pprev_in;
   logic [IW-1:0]    curlink_ff, curlink_in;
   logic [IW-1:0]    occ_ff, occ_in;
   logic             succ_ff, succ_in;
   logic             full_ff, full_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_success_ff, rsp_success_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic [OCC_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_full_ff, rsp_full_in;

   // table port
   logic             wr_en;
   logic [IW-1:0]    wr_slot;
   logic             wr_valid;
   logic [IW-1:0]    wr_link;
   logic [AW-1:0]    wr_home;
   logic [KEY_W-1:0] wr_key;
   logic [EW-1:0]    rd_data;
   logic             rd_valid;
   logic [IW-1:0]    rd_link;
   logic [AW-1:0]    rd_home;
   logic [KEY_W-1:0] rd_key;

   logic             mod_start;
   logic             mod_done;
   logic [AW-1:0]    mod_home;

   // decode of the entry just read
   logic [IW-1:0] rd_next;
   logic          key_hit, next_none, step_end, home_hit, last_slot;
   logic          free_last, outer_end, prev_none, link_hit;

   chm_mod #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .AW         (AW)
   ) u_mod (
      .clock(clock),
      .reset(reset),
      .start(mod_start),
      .key  (req_key),
      .done (mod_done),
      .home (mod_home)
   );

   chm_ram #(
      .DEPTH(TABLE_SLOTS),
      .AW   (AW),
      .DW   (EW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_slot[AW-1:0]),
      .wr_data({wr_valid, wr_link, wr_home, wr_key}),
      .rd_addr(ptr_in[AW-1:0]),
      .rd_data(rd_data)
   );

   assign {rd_valid, rd_link, rd_home, rd_key} = rd_data;

   // a link of the slot count or more ends a chain
   assign rd_next   = (rd_link >= NONE) ? NONE : rd_link;
   assign key_hit   = rd_valid && (rd_key == key_ff);
   assign next_none = (rd_next == NONE);
   assign step_end  = (steps_ff == NONE);
   assign home_hit  = (IW'(rd_home) == cur_ff);
   assign last_slot = (ptr_ff == LAST);
   assign free_last = (free_ff == LAST);
   assign outer_end = (outer_ff == LAST);
   assign prev_none = (prev_ff == NONE);
   assign link_hit  = rd_valid && (rd_link == cur_ff);

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (last_slot) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_HASH;
         end
         ST_HASH: begin
            if (mod_done) begin
               case (op_ff)
                  OP_ADD:    state_in = ST_ADD_HOME;
                  OP_REMOVE: state_in = ST_RM_FIND;
                  OP_SEARCH: state_in = ST_SEARCH;
                  OP_COUNT:  state_in = ST_COUNT;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_HOME: begin
            if (!rd_valid) begin
               state_in = ((home_ff == free_ff) && !free_last) ? ST_FREE : ST_DONE;
            end else if (free_ff == NONE) begin
               state_in = ST_DONE;
            end else begin
               state_in = next_none ? ST_ADD_NEW : ST_ADD_WALK;
            end
         end
         ST_ADD_WALK: begin
            if (step_end || next_none) state_in = ST_ADD_NEW;
         end
         ST_ADD_NEW: begin
            state_in = free_last ? ST_DONE : ST_FREE;
         end
         ST_FREE: begin
            if (!rd_valid || last_slot) state_in = ST_DONE;
         end
         ST_SEARCH: begin
            if (key_hit || next_none || step_end) state_in = ST_DONE;
         end
         ST_COUNT: begin
            if (last_slot) state_in = ST_DONE;
         end
         ST_RM_FIND: begin
            if (key_hit) begin
               if (!next_none) begin
                  state_in = ST_RM_SCAN;
               end else begin
                  state_in = prev_none ? ST_RM_PSCAN : ST_RM_PREV;
               end
            end else if (next_none || step_end) begin
               state_in = ST_DONE;
            end
         end
         ST_RM_SCAN: begin
            if (home_hit) begin
               if (outer_end || next_none) state_in = ST_RM_PREV;
            end else if (next_none || step_end) begin
               state_in = prev_none ? ST_RM_PSCAN : ST_RM_PREV;
            end
         end
         ST_RM_PSCAN: begin
            if (link_hit || last_slot) state_in = ST_RM_CLR;
         end
         ST_RM_PREV:  state_in = ST_RM_CLR;
         ST_RM_CLR:   state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // datapath and table accesses
   // ------------------------------------------------------------------
   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      ptr_in     = ptr_ff;
      home_in    = home_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      steps_in   = steps_ff;
      outer_in   = outer_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      pprev_in   = pprev_ff;
      curlink_in = curlink_ff;
      occ_in     = occ_ff;
      succ_in    = succ_ff;
      full_in    = full_ff;
      mod_start  = 1'b0;

      wr_en    = 1'b0;
      wr_slot  = ptr_ff;
      wr_valid = rd_valid;
      wr_link  = rd_link;
      wr_home  = rd_home;
      wr_key   = rd_key;

      rsp_valid_in   = 1'b0;
      rsp_success_in = rsp_success_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_full_in    = rsp_full_ff;

      case (state_ff)
         ST_CLEAR: begin
            // empty one slot a cycle
            wr_en    = 1'b1;
            wr_valid = 1'b0;
            wr_link  = NONE;
            wr_home  = '0;
            wr_key   = '0;
            ptr_in   = last_slot ? '0 : ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (start) begin
               op_in     = op_type'(req_operation);
               key_in    = req_key;
               mod_start = 1'b1;
               succ_in   = 1'b0;
               full_in   = 1'b0;
               occ_in    = '0;
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               home_in  = IW'(mod_home);
               steps_in = '0;
               prev_in  = NONE;
               ptr_in   = (op_ff == OP_COUNT) ? '0 : IW'(mod_home);
            end
         end
         ST_ADD_HOME: begin
            if (!rd_valid) begin
               // home is free: store there
               wr_en    = 1'b1;
               wr_valid = 1'b1;
               wr_link  = NONE;
               wr_home  = home_ff[AW-1:0];
               wr_key   = key_ff;
               count_in = count_ff + 1'b1;
               succ_in  = 1'b1;
               if (home_ff == free_ff) begin
                  if (free_last) begin
                     free_in = NONE;
                  end else begin
                     ptr_in = free_ff + 1'b1;
                  end
               end
            end else if (free_ff == NONE) begin
               full_in = 1'b1;
            end else if (next_none) begin
               // home is the chain tail: link it to the free slot
               wr_en   = 1'b1;
               wr_link = free_ff;
            end else begin
               ptr_in   = rd_next;
               steps_in = IW'(1);
            end
         end
         ST_ADD_WALK: begin
            if (step_end || next_none) begin
               wr_en   = 1'b1;
               wr_link = free_ff;
            end else begin
               ptr_in   = rd_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_ADD_NEW: begin
            wr_en    = 1'b1;
            wr_slot  = free_ff;
            wr_valid = 1'b1;
            wr_link  = NONE;
            wr_home  = home_ff[AW-1:0];
            wr_key   = key_ff;
            count_in = count_ff + 1'b1;
            succ_in  = 1'b1;
            if (free_last) begin
               free_in = NONE;
            end else begin
               ptr_in = free_ff + 1'b1;
            end
         end
         ST_FREE: begin
            // advance to the next empty slot
            if (!rd_valid) begin
               free_in = ptr_ff;
            end else if (last_slot) begin
               free_in = NONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            if (key_hit) begin
               succ_in = 1'b1;
            end else if (!(next_none || step_end)) begin
               ptr_in   = rd_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_COUNT: begin
            if (key_hit) occ_in = occ_ff + 1'b1;
            if (!last_slot) ptr_in = ptr_ff + 1'b1;
         end
         ST_RM_FIND: begin
            if (key_hit) begin
               cur_in     = ptr_ff;
               curlink_in = rd_link;
               outer_in   = '0;
               steps_in   = '0;
               if (!next_none) begin
                  pprev_in = ptr_ff;
                  ptr_in   = rd_next;
               end else begin
                  ptr_in = prev_none ? '0 : prev_ff;
               end
            end else if (!(next_none || step_end)) begin
               prev_in  = ptr_ff;
               ptr_in   = rd_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_RM_SCAN: begin
            if (home_hit) begin
               // move this member back into the freed place
               wr_en      = 1'b1;
               wr_slot    = cur_ff;
               wr_valid   = 1'b1;
               wr_link    = curlink_ff;
               wr_home    = cur_ff[AW-1:0];
               wr_key     = rd_key;
               prev_in    = pprev_ff;
               cur_in     = ptr_ff;
               curlink_in = rd_link;
               outer_in   = outer_ff + 1'b1;
               steps_in   = '0;
               if (outer_end || next_none) begin
                  ptr_in = pprev_ff;
               end else begin
                  pprev_in = ptr_ff;
                  ptr_in   = rd_next;
               end
            end else if (next_none || step_end) begin
               ptr_in = prev_none ? '0 : prev_ff;
            end else begin
               pprev_in = ptr_ff;
               ptr_in   = rd_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_RM_PSCAN: begin
            // find any slot that links to the freed one
            if (link_hit) begin
               wr_en   = 1'b1;
               wr_link = curlink_ff;
            end else if (!last_slot) begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_RM_PREV: begin
            wr_en   = 1'b1;
            wr_link = curlink_ff;
         end
         ST_RM_CLR: begin
            wr_en    = 1'b1;
            wr_slot  = cur_ff;
            wr_valid = 1'b0;
            wr_link  = NONE;
            wr_home  = '0;
            wr_key   = '0;
            count_in = count_ff - 1'b1;
            succ_in  = 1'b1;
            if (free_ff > cur_ff) free_in = cur_ff;
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_success_in = (op_ff == OP_COUNT) ? (occ_ff != '0) : succ_ff;
            rsp_occ_in     = OCC_W'(occ_ff);
            rsp_total_in   = OCC_W'(count_ff);
            rsp_full_in    = full_ff;
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      home_ff        <= home_in;
      steps_ff       <= steps_in;
      outer_ff       <= outer_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      pprev_ff       <= pprev_in;
      curlink_ff     <= curlink_in;
      occ_ff         <= occ_in;
      succ_ff        <= succ_in;
      full_ff        <= full_in;
      rsp_success_ff <= rsp_success_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_occurrences   = rsp_occ_ff;
   assign rsp_element_total = rsp_total_ff;
   assign rsp_table_full    = rsp_full_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NONE)
      else $error("stored count beyond slot count");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= NONE)
      else $error("free slot pointer out of range");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_success)
      else $error("dropped add reported as stored");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_HASH)
      else $error("transfer not followed by hashing");

endmodule

>>> rtl/chm_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_mod
// Home slot unit: magnitude of a key modulo the slot count, one key byte
// at a time by reciprocal multiplication.
// ----------------------------------------------------------------------------
module chm_mod
   import chm_pkg::*;
#(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int AW          = $clog2(TABLE_SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [AW-1:0]    home
);

   localparam int            RW     = AW + 1;
   localparam int            XW     = AW + 8;
   localparam int            SH     = XW + AW;
   localparam int            MW     = XW + 2;
   localparam int            PW     = XW + MW;
   localparam int            NW     = XW + RW;
   localparam int            DIGITS = KEY_W / 8;
   localparam int            CW     = $clog2(DIGITS);
   localparam logic [RW-1:0] MODV   = RW'(TABLE_SLOTS);
   localparam logic [MW-1:0] RECIP  =
      MW'(((64'd1 << SH) + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS));
   localparam logic [CW-1:0] LASTD  = CW'(DIGITS - 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             phase_ff, phase_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [KEY_W-1:0] mag_ff, mag_in;
   logic [AW-1:0]    rem_ff, rem_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [XW-1:0]    q_ff, q_in;
   logic [PW-1:0]    prod;
   logic [NW-1:0]    diff;

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      prod     = PW'({rem_ff, mag_ff[KEY_W-1 -: 8]}) * PW'(RECIP);
      diff     = NW'(x_ff) - NW'(q_ff) * NW'(MODV);
      if (start) begin
         run_in   = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         rem_in   = '0;
         // take the magnitude; the most negative key maps to 2^31
         mag_in = key[KEY_W-1] ? (~key + 1'b1) : key;
      end else if (run_ff) begin
         if (!phase_ff) begin
            // fold the next byte into the remainder and estimate the quotient
            x_in     = {rem_ff, mag_ff[KEY_W-1 -: 8]};
            q_in     = XW'(prod >> SH);
            mag_in   = {mag_ff[KEY_W-9:0], 8'h00};
            phase_in = 1'b1;
         end else begin
            rem_in   = diff[AW-1:0];
            phase_in = 1'b0;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LASTD) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      x_ff     <= x_in;
      q_ff     <= q_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

>>> rtl/chm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ram
// Slot table: one write and one registered read a cycle, write forwarded.
// ----------------------------------------------------------------------------
module chm_ram
   import chm_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_SLOTS,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = 1 + $clog2(DEPTH + 1) + AW + KEY_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
